FILE: rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and field helpers for the AudioSpecificConfig
// parser.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int unsigned HDR_BYTES = 9;
   localparam int unsigned HDR_W     = 8 * HDR_BYTES;

   localparam logic [3:0] COUNT_SAT    = 4'd10;
   localparam logic [3:0] COUNT_MIN    = 4'd2;
   localparam logic [4:0] AOT_ESCAPE   = 5'd31;
   localparam logic [4:0] AOT_SBR      = 5'd5;
   localparam logic [4:0] AOT_PS       = 5'd29;
   localparam logic [6:0] AOT_ESC_BASE = 7'd32;
   localparam logic [3:0] SFI_EXPLICIT = 4'hF;

   // Bit offsets into the blob, counted from the first bit of byte zero
   localparam logic [6:0] POS_SFI      = 7'd5;
   localparam logic [6:0] POS_SFI_ESC  = 7'd11;
   localparam logic [6:0] POS_RATE     = 7'd9;
   localparam logic [6:0] POS_RATE_ESC = 7'd15;
   localparam logic [6:0] POS_CC       = 7'd9;
   localparam logic [6:0] POS_CC_X     = 7'd33;
   localparam logic [6:0] POS_CC_E     = 7'd15;
   localparam logic [6:0] POS_CC_EX    = 7'd39;
   localparam logic [6:0] POS_EXT      = 7'd13;
   localparam logic [6:0] POS_EXT_X    = 7'd37;
   localparam logic [6:0] POS_EXT_R    = 7'd17;
   localparam logic [6:0] POS_EXT_RX   = 7'd41;

   localparam logic [6:0] END_BASE     = 7'd13;
   localparam logic [6:0] END_ESC      = 7'd6;
   localparam logic [6:0] END_EXPL     = 7'd24;
   localparam logic [6:0] END_EXT      = 7'd4;
   localparam logic [6:0] END_EXT_EXPL = 7'd28;

   typedef struct packed {
      logic [HDR_W-1:0] hdr;
      logic [3:0]       count;
   } snap_type;

   function automatic logic [23:0] rate_lookup(input logic [3:0] idx);
      logic [23:0] r;
      case (idx)
         4'd0:    r = 24'd96000;
         4'd1:    r = 24'd88200;
         4'd2:    r = 24'd64000;
         4'd3:    r = 24'd48000;
         4'd4:    r = 24'd44100;
         4'd5:    r = 24'd32000;
         4'd6:    r = 24'd24000;
         4'd7:    r = 24'd22050;
         4'd8:    r = 24'd16000;
         4'd9:    r = 24'd12000;
         4'd10:   r = 24'd11025;
         4'd11:   r = 24'd8000;
         4'd12:   r = 24'd7350;
         default: r = 24'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] peek4(input logic [HDR_W-1:0] h, input logic [6:0] p);
      logic [6:0] top;
      top = 7'(HDR_W - 1) - p;
      return h[top -: 4];
   endfunction

   function automatic logic [23:0] peek24(input logic [HDR_W-1:0] h,
                                          input logic [6:0] p);
      logic [6:0] top;
      top = 7'(HDR_W - 1) - p;
      return h[top -: 24];
   endfunction

endpackage

FILE: rtl/audio_specific_config_parser.sv
// The result beat is offered once the last byte beat has passed through the snapshot register
// and then the result register; a stalled result holds the snapshot back.
// Throughput: one byte beat per cycle and one blob may end every cycle, unless req_stall is high.
// req_stall is raised while a snapshot waits for the result register to take it.
// Reset clears the header bytes, the byte count and both valid flags.
// ----------------------------------------------------------------------------
// audio_specific_config_parser
// Byte-serial MPEG-4 AudioSpecificConfig header decoder.
// ----------------------------------------------------------------------------
module audio_specific_config_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_parse_ok,
   output logic [6:0]  rsp_object_type,
   output logic [23:0] rsp_sample_rate,
   output logic [3:0]  rsp_channels
);

   asc_pkg::snap_type snap;
   logic              snap_valid;
   logic              snap_take;

   asc_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .snap          (snap),
      .snap_valid    (snap_valid),
      .snap_take     (snap_take)
   );

   asc_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .snap            (snap),
      .snap_valid      (snap_valid),
      .snap_take       (snap_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_parse_ok    (rsp_parse_ok),
      .rsp_object_type (rsp_object_type),
      .rsp_sample_rate (rsp_sample_rate),
      .rsp_channels    (rsp_channels)
   );

endmodule

FILE: rtl/asc_capture.sv
// ----------------------------------------------------------------------------
// asc_capture
// Collects the leading header bytes and the byte count; on the last beat
// hands a snapshot of both to the decoder and clears for the next blob.
// ----------------------------------------------------------------------------
module asc_capture (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output asc_pkg::snap_type snap,
   output logic              snap_valid,
   input  logic              snap_take
);

   logic [asc_pkg::HDR_W-1:0] hdr_ff, hdr_in;
   logic [3:0]                count_ff, count_in;
   asc_pkg::snap_type         snap_ff, snap_in;
   logic                      snap_valid_ff, snap_valid_in;
   logic [asc_pkg::HDR_W-1:0] hdr_next;
   logic [3:0]                count_next;
   logic                      accept;

   assign req_stall = snap_valid_ff && !snap_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hdr_next = hdr_ff;
      for (int i = 0; i < asc_pkg::HDR_BYTES; i++) begin
         if (count_ff == 4'(i)) begin
            hdr_next[asc_pkg::HDR_W-1-8*i -: 8] = req_data_byte;
         end
      end
      count_next = (count_ff < asc_pkg::COUNT_SAT) ? count_ff + 4'd1 : count_ff;

      hdr_in        = hdr_ff;
      count_in      = count_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff && !snap_take;
      if (accept) begin
         if (req_last_byte) begin
            // hand off the full blob and start over
            snap_in.hdr   = hdr_next;
            snap_in.count = count_next;
            snap_valid_in = 1'b1;
            hdr_in        = '0;
            count_in      = '0;
         end else begin
            hdr_in   = hdr_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff        <= '0;
         count_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         hdr_ff        <= hdr_in;
         count_ff      <= count_in;
         snap_valid_ff <= snap_valid_in;
      end
      snap_ff <= snap_in;
   end

   assign snap       = snap_ff;
   assign snap_valid = snap_valid_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> count_ff == 4'd0 && hdr_ff == '0)
      else $error("capture state not cleared after last beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= asc_pkg::COUNT_SAT)
      else $error("byte count beyond saturation");

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_take |=> snap_valid_ff && $stable(snap_ff))
      else $error("pending snapshot lost or changed");

endmodule

FILE: rtl/asc_decode.sv
// ----------------------------------------------------------------------------
// asc_decode
// Extracts object type, sample rate and channel count from a captured
// header and holds the answer in the result register.
// ----------------------------------------------------------------------------
module asc_decode (
   input  logic              clock,
   input  logic              reset,
   input  asc_pkg::snap_type snap,
   input  logic              snap_valid,
   output logic              snap_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_parse_ok,
   output logic [6:0]        rsp_object_type,
   output logic [23:0]       rsp_sample_rate,
   output logic [3:0]        rsp_channels
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      ok_ff, ok_in;
   logic [6:0]                aot_ff, aot_in;
   logic [23:0]               rate_ff, rate_in;
   logic [3:0]                ch_ff, ch_in;

   logic [asc_pkg::HDR_W-1:0] h;
   logic [4:0]                aot5;
   logic                      esc, expl, sbr, ext_expl, in_range, ok;
   logic [6:0]                aot;
   logic [3:0]                sfi, cc, ext_idx;
   logic [23:0]               core_rate, ext_rate, rate;
   logic [6:0]                end_pos, limit;

   assign snap_take = snap_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      h    = snap.hdr;
      aot5 = h[asc_pkg::HDR_W-1 -: 5];
      esc  = aot5 == asc_pkg::AOT_ESCAPE;
      aot  = esc ? asc_pkg::AOT_ESC_BASE + {1'b0, h[asc_pkg::HDR_W-6 -: 6]}
                 : {2'b00, aot5};
      sfi  = esc ? asc_pkg::peek4(h, asc_pkg::POS_SFI_ESC)
                 : asc_pkg::peek4(h, asc_pkg::POS_SFI);
      expl = sfi == asc_pkg::SFI_EXPLICIT;
      if (expl) begin
         core_rate = esc ? asc_pkg::peek24(h, asc_pkg::POS_RATE_ESC)
                         : asc_pkg::peek24(h, asc_pkg::POS_RATE);
      end else begin
         core_rate = asc_pkg::rate_lookup(sfi);
      end

      case ({esc, expl})
         2'b00:   cc = asc_pkg::peek4(h, asc_pkg::POS_CC);
         2'b01:   cc = asc_pkg::peek4(h, asc_pkg::POS_CC_X);
         2'b10:   cc = asc_pkg::peek4(h, asc_pkg::POS_CC_E);
         default: cc = asc_pkg::peek4(h, asc_pkg::POS_CC_EX);
      endcase

      // escaped types are at least 32, so SBR only shows up unescaped
      sbr      = !esc && (aot5 == asc_pkg::AOT_SBR || aot5 == asc_pkg::AOT_PS);
      ext_idx  = expl ? asc_pkg::peek4(h, asc_pkg::POS_EXT_X)
                      : asc_pkg::peek4(h, asc_pkg::POS_EXT);
      ext_expl = ext_idx == asc_pkg::SFI_EXPLICIT;
      if (ext_expl) begin
         ext_rate = expl ? asc_pkg::peek24(h, asc_pkg::POS_EXT_RX)
                         : asc_pkg::peek24(h, asc_pkg::POS_EXT_R);
      end else begin
         ext_rate = asc_pkg::rate_lookup(ext_idx);
      end

      end_pos = asc_pkg::END_BASE
              + (esc  ? asc_pkg::END_ESC  : 7'd0)
              + (expl ? asc_pkg::END_EXPL : 7'd0)
              + (sbr  ? (ext_expl ? asc_pkg::END_EXT_EXPL : asc_pkg::END_EXT) : 7'd0);
      limit    = {snap.count, 3'b000};
      in_range = end_pos <= limit;

      rate = (sbr && in_range && ext_rate != 24'd0) ? ext_rate : core_rate;
      ok   = snap.count >= asc_pkg::COUNT_MIN && in_range && rate != 24'd0;

      ok_in   = ok_ff;
      aot_in  = aot_ff;
      rate_in = rate_ff;
      ch_in   = ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (snap_take) begin
         rsp_valid_in = 1'b1;
         ok_in        = ok;
         aot_in       = ok ? aot  : 7'd0;
         rate_in      = ok ? rate : 24'd0;
         if (!ok || cc == 4'd0 || cc > 4'd7) begin
            ch_in = 4'd0;
         end else if (cc == 4'd7) begin
            ch_in = 4'd8;
         end else begin
            ch_in = cc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff   <= ok_in;
      aot_ff  <= aot_in;
      rate_ff <= rate_in;
      ch_ff   <= ch_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_parse_ok    = ok_ff;
   assign rsp_object_type = aot_ff;
   assign rsp_sample_rate = rate_ff;
   assign rsp_channels    = ch_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> aot_ff == 7'd0 && rate_ff == 24'd0 && ch_ff == 4'd0)
      else $error("failed parse carries nonzero fields");

   a_ok_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ok_ff |-> rate_ff != 24'd0)
      else $error("successful parse with zero rate");

   a_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ch_ff <= 4'd8 && ch_ff != 4'd7)
      else $error("channel count out of range");

endmodule
